// ===== rtl/icc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icc_pkg
// Shared widths, register and theme codes, and constant tables of the
// iteration count colormap.
// ----------------------------------------------------------------------------
package icc_pkg;

  localparam int CNT_W     = 24;
  localparam int X_W       = 25;
  localparam int K_W       = 5;
  localparam int MANT_BITS = 30;
  localparam int M_W       = 31;
  localparam int LV_W      = 8;
  localparam int CH_W      = 8;
  localparam int THEME_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;
  localparam int RAMP_W    = 18;
  localparam int GSEG_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THEME    = 1'd1;

  localparam logic [THEME_W-1:0] TH_CLASSIC  = 3'd0;
  localparam logic [THEME_W-1:0] TH_FIRE     = 3'd1;
  localparam logic [THEME_W-1:0] TH_ICE      = 3'd2;
  localparam logic [THEME_W-1:0] TH_RAINBOW  = 3'd3;
  localparam logic [THEME_W-1:0] TH_GRADIENT = 3'd4;
  localparam logic [THEME_W-1:0] TH_GRAY     = 3'd5;

  localparam logic [23:0] RECIP_255 = 24'd263173;

  typedef struct packed {
    logic           in_range;
    logic [X_W-1:0] xn;
  } item_t;

  // Exact floor(x / 255) for any x below 2^18.
  function automatic logic [10:0] div255(input logic [RAMP_W-1:0] x);
    logic [41:0] p;
    p = {24'd0, x} * {18'd0, RECIP_255};
    return p[36:26];
  endfunction

  function automatic logic [CH_W-1:0] sat8(input logic [10:0] v);
    return (v > 11'd255) ? 8'd255 : v[7:0];
  endfunction

  // x - c, floored at zero.
  function automatic logic [RAMP_W-1:0] sub_clip(input logic [RAMP_W-1:0] x,
                                                 input logic [RAMP_W-1:0] c);
    return (x > c) ? (x - c) : '0;
  endfunction

  function automatic logic [8:0] grad_pos(input logic [GSEG_W-1:0] i);
    case (i)
      4'd0:    return 9'd0;
      4'd1:    return 9'd4;
      4'd2:    return 9'd8;
      4'd3:    return 9'd16;
      4'd4:    return 9'd32;
      4'd5:    return 9'd64;
      4'd6:    return 9'd96;
      4'd7:    return 9'd128;
      4'd8:    return 9'd160;
      4'd9:    return 9'd192;
      4'd10:   return 9'd224;
      default: return 9'd256;
    endcase
  endfunction

  // log2 of the width of the segment that starts at stop i.
  function automatic logic [2:0] grad_sh(input logic [GSEG_W-1:0] i);
    case (i)
      4'd0, 4'd1: return 3'd2;
      4'd2:       return 3'd3;
      4'd3:       return 3'd4;
      default:    return 3'd5;
    endcase
  endfunction

  function automatic logic [23:0] grad_rgb(input logic [GSEG_W-1:0] i);
    case (i)
      4'd0:    return {8'd0,   8'd0,   8'd0};
      4'd1:    return {8'd0,   8'd0,   8'd51};
      4'd2:    return {8'd0,   8'd0,   8'd102};
      4'd3:    return {8'd0,   8'd0,   8'd204};
      4'd4:    return {8'd0,   8'd102, 8'd255};
      4'd5:    return {8'd0,   8'd204, 8'd255};
      4'd6:    return {8'd0,   8'd255, 8'd204};
      4'd7:    return {8'd204, 8'd255, 8'd0};
      4'd8:    return {8'd255, 8'd204, 8'd0};
      4'd9:    return {8'd255, 8'd102, 8'd0};
      4'd10:   return {8'd255, 8'd51,  8'd0};
      default: return {8'd204, 8'd0,   8'd0};
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/icc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icc_front
// Input side: classifies each count against the limit and holds it in a
// short queue until the back pipeline takes it.
// ----------------------------------------------------------------------------
module icc_front #(
  parameter int DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [icc_pkg::CNT_W-1:0]   iteration_count,
  input  wire logic [icc_pkg::CNT_W-1:0]   max_iterations,
  input  wire logic                        take,
  output logic                             item_valid,
  output icc_pkg::item_t                   item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  icc_pkg::item_t     mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_QW-1:0]  count;
  logic               wr;
  logic               rd;

  assign full       = (count == CNT_QW'(DEPTH));
  assign item_valid = (count != '0);
  assign item       = mem[rptr];
  assign wr         = push && !full;
  assign rd         = take && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr].in_range <= (iteration_count < max_iterations);
      mem[wptr].xn       <= {1'b0, iteration_count} + icc_pkg::X_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_QW'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/icc_log2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icc_log2
// Pipelined fixed-point log2: leading-one stage, normalize stage, then one
// mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
module icc_log2 #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [icc_pkg::X_W-1:0]               x,
  output logic [icc_pkg::K_W+FRAC_BITS-1:0]          res
);

  localparam int RW = icc_pkg::K_W + FRAC_BITS;
  localparam int MW = icc_pkg::M_W;

  logic [icc_pkg::X_W-1:0] x_s1;
  logic [icc_pkg::K_W-1:0] k_s1;
  logic [icc_pkg::K_W-1:0] k_c;
  logic [MW-1:0]           m [FRAC_BITS+1];
  logic [RW-1:0]           r [FRAC_BITS+1];

  always_comb begin
    k_c = '0;
    for (int i = 1; i < icc_pkg::X_W; i++) begin
      if (x[i]) k_c = icc_pkg::K_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1 <= x;
      k_s1 <= k_c;
      m[0] <= MW'(x_s1) << (icc_pkg::K_W'(icc_pkg::MANT_BITS) - k_s1);
      r[0] <= RW'(k_s1);
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     mn;
    assign sq = {{MW{1'b0}}, m[j]} * {{MW{1'b0}}, m[j]};
    assign mn = sq[2*icc_pkg::MANT_BITS+1:icc_pkg::MANT_BITS];
    always_ff @(posedge clk) begin
      if (en) begin
        m[j+1] <= mn[MW] ? mn[MW:1] : mn[MW-1:0];
        r[j+1] <= {r[j][RW-2:0], mn[MW]};
      end
    end
  end

  assign res = r[FRAC_BITS];

endmodule
`default_nettype wire

// ===== rtl/icc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icc_div
// Pipelined restoring divider: level = floor(255 * num / den), one quotient
// bit per stage. A zero denominator gives level 0.
// ----------------------------------------------------------------------------
module icc_div #(
  parameter int NUM_W = 21
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [NUM_W-1:0]          num,
  input  wire logic [NUM_W-1:0]          den,
  output logic [icc_pkg::LV_W-1:0]       level
);

  localparam int W  = NUM_W + icc_pkg::LV_W;
  localparam int QB = icc_pkg::LV_W;

  logic [W-1:0]     rem [QB+1];
  logic [NUM_W-1:0] dd  [QB+1];
  logic [QB-1:0]    q   [QB+1];
  logic             z   [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (W'(num) << QB) - W'(num);
      dd[0]  <= den;
      q[0]   <= '0;
      z[0]   <= (den == '0);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [W-1:0] cand;
    logic         tk;
    assign cand = W'(dd[s]) << (QB - 1 - s);
    assign tk   = !z[s] && (rem[s] >= cand);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= tk ? rem[s] - cand : rem[s];
        dd[s+1]  <= dd[s];
        z[s+1]   <= z[s];
        q[s+1]   <= q[s] | (QB'(tk) << (QB - 1 - s));
      end
    end
  end

  assign level = q[QB];

endmodule
`default_nettype wire

// ===== rtl/icc_theme.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icc_theme
// Three-stage theme mapper from level to red, green and blue.
// ----------------------------------------------------------------------------
module icc_theme (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [icc_pkg::LV_W-1:0]      lv,
  input  wire logic [icc_pkg::THEME_W-1:0]   theme,
  output logic [icc_pkg::LV_W-1:0]           level,
  output logic [icc_pkg::CH_W-1:0]           red,
  output logic [icc_pkg::CH_W-1:0]           green,
  output logic [icc_pkg::CH_W-1:0]           blue
);

  localparam int RW = icc_pkg::RAMP_W;

  // Stage 1 results.
  logic [icc_pkg::LV_W-1:0]    lv1;
  logic [icc_pkg::THEME_W-1:0] th1;
  logic [RW-1:0]               nr1, ng1, nb1;
  logic [2:0]                  sec1;
  logic [7:0]                  rem1;
  logic [icc_pkg::GSEG_W-1:0]  seg1;
  logic                        last1;
  logic [15:0]                 gx1;

  // Stage 2 results.
  logic [icc_pkg::LV_W-1:0]    lv2;
  logic [icc_pkg::THEME_W-1:0] th2;
  logic [7:0]                  rr2, rg2, rb2;
  logic [2:0]                  sec2;
  logic [15:0]                 pt2, pq2;
  logic [icc_pkg::GSEG_W-1:0]  seg2;
  logic                        last2;
  logic [7:0]                  t82;

  // Stage 1 logic.
  logic [RW-1:0]              l18;
  logic [RW-1:0]              cr, cg, cb;
  logic [10:0]                six;
  logic [2:0]                 sraw;
  logic [15:0]                pos;
  logic [icc_pkg::GSEG_W-1:0] seg_c;
  logic [16:0]                base;
  logic [15:0]                diff;
  logic [23:0]                gxw;

  always_comb begin
    l18 = RW'(lv);
    case (theme)
      icc_pkg::TH_FIRE: begin
        cr = l18 << 9;
        cg = icc_pkg::sub_clip(l18 << 9, RW'(65280));
        cb = icc_pkg::sub_clip(l18 << 10, RW'(195840));
      end
      icc_pkg::TH_ICE: begin
        cb = l18 << 9;
        cg = icc_pkg::sub_clip(l18 << 9, RW'(65280));
        cr = icc_pkg::sub_clip(l18 << 10, RW'(195840));
      end
      default: begin
        cr = l18 * RW'(400);
        cg = icc_pkg::sub_clip(l18 * RW'(640), RW'(97920));
        cb = l18 * RW'(600);
      end
    endcase

    six  = 11'(lv) * 11'd6;
    sraw = '0;
    for (int k = 1; k < 7; k++) begin
      if (six >= 11'(255 * k)) sraw = 3'(k);
    end

    pos   = {lv, 8'd0};
    seg_c = '0;
    for (int j = 1; j < 11; j++) begin
      if (17'(pos) >= 17'(icc_pkg::grad_pos(icc_pkg::GSEG_W'(j))) * 17'd255) begin
        seg_c = icc_pkg::GSEG_W'(j);
      end
    end
    base = 17'(icc_pkg::grad_pos(seg_c)) * 17'd255;
    diff = 16'(17'(pos) - base);
    gxw  = {diff, 8'd0} >> icc_pkg::grad_sh(seg_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv1   <= lv;
      th1   <= theme;
      nr1   <= cr;
      ng1   <= cg;
      nb1   <= cb;
      sec1  <= (sraw == 3'd6) ? 3'd0 : sraw;
      rem1  <= 8'(six - 11'(sraw) * 11'd255);
      seg1  <= seg_c;
      last1 <= (lv == 8'd255);
      gx1   <= gxw[15:0];
    end
  end

  // Stage 2: divisions by 255 of the ramps and the gradient position, and the rainbow products.
  always_ff @(posedge clk) begin
    if (en) begin
      lv2   <= lv1;
      th2   <= th1;
      rr2   <= icc_pkg::sat8(icc_pkg::div255(nr1));
      rg2   <= icc_pkg::sat8(icc_pkg::div255(ng1));
      rb2   <= icc_pkg::sat8(icc_pkg::div255(nb1));
      sec2  <= sec1;
      pt2   <= 16'(lv1) * 16'(rem1);
      pq2   <= 16'(lv1) * 16'(8'd255 - rem1);
      seg2  <= seg1;
      last2 <= last1;
      t82   <= icc_pkg::sat8(icc_pkg::div255(RW'(gx1)));
    end
  end

  // Stage 3: rainbow sector select, gradient interpolation, theme select.
  logic [7:0]  rt, rq;
  logic [7:0]  hr, hg, hb;
  logic [23:0] c0, c1, gc;
  logic [7:0]  gr, gg, gb;
  logic [7:0]  o_r, o_g, o_b;

  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] t);
    logic signed [19:0] v;
    v = $signed({4'd0, a, 8'd0})
        + $signed({12'd0, t}) * ($signed({12'd0, b}) - $signed({12'd0, a}));
    return v[15:8];
  endfunction

  always_comb begin
    rt = icc_pkg::sat8(icc_pkg::div255(RW'(pt2)));
    rq = icc_pkg::sat8(icc_pkg::div255(RW'(pq2)));
    case (sec2)
      3'd0:    begin hr = lv2; hg = rt;  hb = '0;  end
      3'd1:    begin hr = rq;  hg = lv2; hb = '0;  end
      3'd2:    begin hr = '0;  hg = lv2; hb = rt;  end
      3'd3:    begin hr = '0;  hg = rq;  hb = lv2; end
      3'd4:    begin hr = rt;  hg = '0;  hb = lv2; end
      default: begin hr = lv2; hg = '0;  hb = rq;  end
    endcase

    c0 = icc_pkg::grad_rgb(seg2);
    c1 = icc_pkg::grad_rgb(seg2 + icc_pkg::GSEG_W'(1));
    gc = icc_pkg::grad_rgb(icc_pkg::GSEG_W'(11));
    if (last2) begin
      gr = gc[23:16];
      gg = gc[15:8];
      gb = gc[7:0];
    end else begin
      gr = lerp(c0[23:16], c1[23:16], t82);
      gg = lerp(c0[15:8],  c1[15:8],  t82);
      gb = lerp(c0[7:0],   c1[7:0],   t82);
    end

    case (th2)
      icc_pkg::TH_RAINBOW:  begin o_r = hr; o_g = hg; o_b = hb; end
      icc_pkg::TH_GRADIENT: begin o_r = gr; o_g = gg; o_b = gb; end
      icc_pkg::TH_GRAY:     begin o_r = '0; o_g = '0; o_b = '0; end
      default:              begin o_r = rr2; o_g = rg2; o_b = rb2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level <= lv2;
      red   <= o_r;
      green <= o_g;
      blue  <= o_b;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/iteration_count_colormap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iteration_count_colormap
// Log-scaled colour map for fractal escape-iteration counts.
// ----------------------------------------------------------------------------
// Pipeline: one squaring stage per log fraction bit lies between an accepted
//   item and its result.
// Throughput: one item per cycle, sustained, while pop keeps up.
// Reset (rst, synchronous): queue and pipeline empty, max_iterations = 256,
//   theme_select = classic. No clearing pass.
// ----------------------------------------------------------------------------
module iteration_count_colormap #(
  parameter int LOG_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [icc_pkg::CNT_W-1:0]       iteration_count,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [icc_pkg::LV_W-1:0]             level,
  output logic [icc_pkg::CH_W-1:0]             red,
  output logic [icc_pkg::CH_W-1:0]             green,
  output logic [icc_pkg::CH_W-1:0]             blue,
  input  wire logic                            cfg_write,
  input  wire logic [icc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [icc_pkg::CFG_W-1:0]       cfg_data
);

  // The front classifies each item and queues it. The back is one pipeline
  // that advances as a whole whenever its last stage is free or being popped;
  // that last stage is the result register seen on the output ports.
  localparam int RW      = icc_pkg::K_W + LOG_FRAC_BITS;
  localparam int LOG_LAT = 1 + 2 + LOG_FRAC_BITS;
  localparam int VL      = LOG_LAT + 9 + 3;

  logic [icc_pkg::CNT_W-1:0]   max_iterations;
  logic [icc_pkg::THEME_W-1:0] theme_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= icc_pkg::CNT_W'(256);
      theme_select   <= icc_pkg::TH_CLASSIC;
    end else if (cfg_write) begin
      case (cfg_index)
        icc_pkg::REG_MAX_ITER: max_iterations <= cfg_data;
        icc_pkg::REG_THEME:    theme_select   <= cfg_data[icc_pkg::THEME_W-1:0];
        default: ;
      endcase
    end
  end

  logic           adv;
  logic           q_valid;
  icc_pkg::item_t q_item;

  icc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .iteration_count (iteration_count),
    .max_iterations  (max_iterations),
    .take            (adv),
    .item_valid      (q_valid),
    .item            (q_item)
  );

  // Valid bits for every back stage, and the in-range flag up to the divider.
  logic [VL-1:0]      vld;
  logic [LOG_LAT-1:0] inr;

  assign empty = !vld[VL-1];
  assign adv   = empty || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VL-2:0], q_valid};
    end
  end

  logic [icc_pkg::X_W-1:0] xn0;
  logic [icc_pkg::X_W-1:0] xd0;

  always_ff @(posedge clk) begin
    if (adv) begin
      inr <= {inr[LOG_LAT-2:0], q_item.in_range};
      xn0 <= q_item.xn;
      xd0 <= {1'b0, max_iterations} + icc_pkg::X_W'(1);
    end
  end

  logic [RW-1:0] log_num;
  logic [RW-1:0] log_den;

  icc_log2 #(.FRAC_BITS(LOG_FRAC_BITS)) u_log_num (
    .clk (clk),
    .en  (adv),
    .x   (xn0),
    .res (log_num)
  );

  icc_log2 #(.FRAC_BITS(LOG_FRAC_BITS)) u_log_den (
    .clk (clk),
    .en  (adv),
    .x   (xd0),
    .res (log_den)
  );

  // A count at or above the limit divides a zero numerator: level 0.
  logic [RW-1:0]            num_eff;
  logic [icc_pkg::LV_W-1:0] lv;

  assign num_eff = inr[LOG_LAT-1] ? log_num : '0;

  icc_div #(.NUM_W(RW)) u_div (
    .clk   (clk),
    .en    (adv),
    .num   (num_eff),
    .den   (log_den),
    .level (lv)
  );

  icc_theme u_theme (
    .clk   (clk),
    .en    (adv),
    .lv    (lv),
    .theme (theme_select),
    .level (level),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

endmodule
`default_nettype wire

// ===== tb/iteration_count_colormap_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iteration_count_colormap_test
// Self-checking bench for the log-scaled fractal colour map. A clocked driver
// pushes escape counts from a queue that the stimulus process fills. A clocked
// monitor pops results and compares them with colours computed by a local
// integer predictor, across iteration limits and every theme.
// ----------------------------------------------------------------------------
module iteration_count_colormap_test;

  localparam int FRAC_BITS = 16;
  // The pipeline is LOG_FRAC_BITS + 15 deep; settle a little beyond that.
  localparam int SETTLE = 64;

  typedef struct packed {
    logic [7:0] lv;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [icc_pkg::CNT_W-1:0] iteration_count = '0;
  logic cfg_write = 1'b0;
  logic [icc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [icc_pkg::CFG_W-1:0] cfg_data = '0;
  logic full, empty;
  logic [7:0] level, red, green, blue;

  iteration_count_colormap dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .iteration_count(iteration_count), .empty(empty), .pop(pop),
    .level(level), .red(red), .green(green), .blue(blue),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor's own copy of the two registers.
  logic [23:0] limit_reg = 24'd256;
  logic [2:0] theme_reg = icc_pkg::TH_CLASSIC;

  logic [icc_pkg::CNT_W-1:0] pending_counts[$];
  pixel_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  // Fixed-point log2: leading-one position, then fraction bits by squaring
  // the Q1.30 mantissa and truncating each time.
  function automatic longint unsigned log2_q(input int unsigned x);
    int unsigned k;
    longint unsigned m, res;
    if (x == 0) return 0;
    k = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = longint'(x) << (30 - k);
    res = k;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      res = res << 1;
      if (m >= (64'd2 << 30)) begin
        res = res | 1;
        m = m >> 1;
      end
    end
    return res;
  endfunction

  // Floor of num/255 clamped to 0..255.
  function automatic logic [7:0] clamp_ramp(input longint num);
    longint v;
    if (num <= 0) return 8'd0;
    v = num / 255;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // The gradient's twelve stop colours, packed red, green, blue.
  function automatic logic [23:0] grad_color(input int unsigned i);
    case (i)
      0: return 24'h000000;
      1: return {8'd0, 8'd0, 8'd51};
      2: return {8'd0, 8'd0, 8'd102};
      3: return {8'd0, 8'd0, 8'd204};
      4: return {8'd0, 8'd102, 8'd255};
      5: return {8'd0, 8'd204, 8'd255};
      6: return {8'd0, 8'd255, 8'd204};
      7: return {8'd204, 8'd255, 8'd0};
      8: return {8'd255, 8'd204, 8'd0};
      9: return {8'd255, 8'd102, 8'd0};
      10: return {8'd255, 8'd51, 8'd0};
      default: return {8'd204, 8'd0, 8'd0};
    endcase
  endfunction

  function automatic pixel_t colorize(input logic [23:0] cnt);
    pixel_t p;
    longint unsigned num, den, q;
    longint lv;
    int unsigned six, sector, rem, hv, ht, hq, pos, i, span, t8;
    int unsigned stops[12] = '{0, 4, 8, 16, 32, 64, 96, 128, 160, 192, 224, 256};
    logic [23:0] c0w, c1w;
    int c0, dd, v;
    p = '0;
    if (cnt < limit_reg) begin
      den = log2_q(int'(limit_reg) + 1);
      num = log2_q(int'(cnt) + 1);
      if (den != 0) begin
        q = (num * 255) / den;
        p.lv = (q > 255) ? 8'd255 : q[7:0];
      end
    end
    lv = p.lv;
    case (theme_reg)
      icc_pkg::TH_FIRE: begin
        p.r = clamp_ramp(512 * lv);
        p.g = clamp_ramp(512 * lv - 65280);
        p.b = clamp_ramp(1024 * lv - 195840);
      end
      icc_pkg::TH_ICE: begin
        p.b = clamp_ramp(512 * lv);
        p.g = clamp_ramp(512 * lv - 65280);
        p.r = clamp_ramp(1024 * lv - 195840);
      end
      icc_pkg::TH_RAINBOW: begin
        six = lv * 6;
        sector = (six / 255) % 6;
        rem = six % 255;
        hv = lv;
        ht = (lv * rem) / 255;
        hq = (lv * (255 - rem)) / 255;
        case (sector)
          0: begin p.r = hv; p.g = ht; p.b = 0; end
          1: begin p.r = hq; p.g = hv; p.b = 0; end
          2: begin p.r = 0; p.g = hv; p.b = ht; end
          3: begin p.r = 0; p.g = hq; p.b = hv; end
          4: begin p.r = ht; p.g = 0; p.b = hv; end
          default: begin p.r = hv; p.g = 0; p.b = hq; end
        endcase
      end
      icc_pkg::TH_GRADIENT: begin
        if (lv >= 255) begin
          p.r = 8'd204; p.g = 8'd0; p.b = 8'd0;
        end else begin
          pos = lv * 256;
          i = 0;
          while (i < 10 && pos >= stops[i + 1] * 255) i++;
          span = (stops[i + 1] - stops[i]) * 255;
          t8 = ((pos - stops[i] * 255) * 256) / span;
          if (t8 > 255) t8 = 255;
          c0w = grad_color(i);
          c1w = grad_color(i + 1);
          for (int c = 0; c < 3; c++) begin
            c0 = c0w[23 - 8 * c -: 8];
            dd = int'(c1w[23 - 8 * c -: 8]) - c0;
            v = c0 * 256 + int'(t8) * dd;
            if (v < 0) v = 0;
            v = v / 256;
            if (v > 255) v = 255;
            case (c)
              0: p.r = v[7:0];
              1: p.g = v[7:0];
              default: p.b = v[7:0];
            endcase
          end
        end
      end
      icc_pkg::TH_GRAY: begin
        p.r = 0; p.g = 0; p.b = 0;
      end
      default: begin
        // Classic, and also the two undefined theme codes.
        p.r = clamp_ramp(400 * lv);
        p.g = clamp_ramp(640 * lv - 97920);
        p.b = clamp_ramp(600 * lv);
      end
    endcase
    return p;
  endfunction

  // Driver: push is only lowered or the next count presented at an edge, and
  // the count is predicted at the edge where the handshake completes.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_pixels.push_back(colorize(iteration_count));
        void'(pending_counts.pop_front());
      end
      if ((!push || !full) && pending_counts.size() > 0 &&
          !(push && !full && pending_counts.size() == 0)) begin
        if (push && !full) begin
          if (pending_counts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            iteration_count <= pending_counts[0];
            push <= 1'b1;
          end else begin
            push <= 1'b0;
          end
        end else if ($urandom_range(99) >= send_idle_pct) begin
          iteration_count <= pending_counts[0];
          push <= 1'b1;
        end
      end else if (push && !full) begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: a result moves when pop and not empty meet at an edge.
  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: level %0d rgb %0d %0d %0d",
                     level, red, green, blue);
        end else begin
          exp_p = expected_pixels.pop_front();
          if (exp_p !== {level, red, green, blue}) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected lv %0d rgb %0d %0d %0d, ",
                        "got lv %0d rgb %0d %0d %0d"},
                       exp_p.lv, exp_p.r, exp_p.g, exp_p.b, level, red, green, blue);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_idle();
    while (pending_counts.size() > 0 || push || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [icc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == icc_pkg::REG_MAX_ITER) limit_reg = val;
    else theme_reg = val[2:0];
  endtask

  // Counts up to the limit, tiny counts, counts near the limit and fully random counts in a mix.
  function automatic logic [23:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5 || limit_reg < 2) return $urandom_range(limit_reg);
    if (sel < 7) return $urandom_range(15);
    if (sel < 8) return limit_reg - $urandom_range(limit_reg > 3 ? 3 : limit_reg);
    return $urandom;
  endfunction

  initial begin
    logic [23:0] limits[6] = '{24'd256, 24'd1, 24'hFFFFFF, 24'd1000, 24'd0, 24'd65535};
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of the count at the reset limit and in each theme.
    for (int th = 0; th < 8; th++) begin
      write_reg(icc_pkg::REG_THEME, 24'(th));
      pending_counts.push_back(24'd0);
      pending_counts.push_back(24'd1);
      pending_counts.push_back(24'd255);
      wait_idle();
    end
    write_reg(icc_pkg::REG_MAX_ITER, 24'hFFFFFF);
    write_reg(icc_pkg::REG_THEME, 24'(icc_pkg::TH_RAINBOW));
    pending_counts.push_back(24'hFFFFFF);
    pending_counts.push_back(24'hFFFFFE);
    pending_counts.push_back(24'h800000);
    pending_counts.push_back(24'h555555);
    pending_counts.push_back(24'hAAAAAA);
    wait_idle();

    // Random phases: each changes the limit and theme while idle.
    phase = 0;
    for (int k = 0; k < 24; k++) begin
      if (k < 8) begin
        send_idle_pct = 15; recv_idle_pct = 58;
      end else if (k < 16) begin
        send_idle_pct = 58; recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(icc_pkg::REG_MAX_ITER, (k % 3 == 2) ? 24'($urandom) : limits[k % 6]);
      write_reg(icc_pkg::REG_THEME, 24'($urandom_range(7)));
      for (int n = 0; n < 42; n++) pending_counts.push_back(pick_count());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("iteration_count_colormap regression: pass");
    end else begin
      $display("iteration_count_colormap regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("iteration_count_colormap regression: fail");
    $finish;
  end
endmodule
